// ===== hdl/axis_angle_vector_rotator_defines.svh =====
// assertion macros used by the rotator module
`ifndef AXIS_ANGLE_VECTOR_ROTATOR_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATOR_DEFINES_SVH

// condition in this cycle implies consequence in this cycle
`define AAVR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define AAVR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hdl/aavr_pkg.sv =====
// ---------------------------------------------------------------------------
// aavr_pkg
// Types, codes and tables of the axis-angle vector rotator.
// ---------------------------------------------------------------------------
package aavr_pkg;

  // input beat: one point in Q16.16
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  // output beat: rotated point and clip flag
  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               saturated;
  } result_t;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_AXIS_X = 4'd0,
    REG_AXIS_Y = 4'd1,
    REG_AXIS_Z = 4'd2,
    REG_ANGLE  = 4'd3
  } cfg_reg_t;

  // matrix rebuild sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_CORDIC,
    ST_COEF,
    ST_COMBINE
  } state_t;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/axis_angle_vector_rotator.sv =====
// ---------------------------------------------------------------------------
// axis_angle_vector_rotator
// Rotates Q16.16 points about a configured axis by a configured angle.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   axis_x, axis_y, axis_z and rotation_angle. Each write to a known index
//   rebuilds the Q2.30 rotation matrix with a sequencer around one shared
//   34x34 multiplier, a bit-per-cycle square root, a bit-per-cycle divider
//   and a CORDIC; busy and !cfg_ready mark the rebuild. Points enter on
//   start while busy is low, one beat per cycle. The datapath is four
//   register stages: input, nine products, row sums with rounding,
//   saturation. A result appears with done for one cycle out of the
//   saturation stage, at one result per cycle.
//   The receiver cannot stall; results are never held.
//   Reset loads axis (0,0,1), angle 0 and the identity matrix; no rebuild
//   runs after reset.
// ---------------------------------------------------------------------------
`include "axis_angle_vector_rotator_defines.svh"

module axis_angle_vector_rotator
  import aavr_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      point,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic        [15:0] rotation_angle;
  logic signed [31:0] coef [0:8];

  // sequencer control
  state_t     state, state_next;
  logic [5:0] cnt;
  logic [1:0] ai;

  // rebuild working registers
  logic        [31:0] sum;
  logic        [59:0] sq_n, sq_res, sq_bit;
  logic        [31:0] r_val;
  logic        [59:0] num, quo;
  logic        [31:0] rem;
  logic signed [33:0] ux, uy, uz;
  logic signed [33:0] cx, cy, cz;
  logic               flip;
  logic signed [33:0] cos_v, sin_v;
  logic signed [67:0] mul_p;
  logic signed [33:0] tmp [0:8];

  logic cfg_we, cfg_known;
  assign cfg_ready = (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == REG_AXIS_X) || (cfg_index == REG_AXIS_Y) ||
                     (cfg_index == REG_AXIS_Z) || (cfg_index == REG_ANGLE);

  // axis component picked by a two-bit index
  logic signed [15:0] axis_sel;
  always_comb begin
    case (state == ST_SUMSQ ? cnt[1:0] : ai)
      2'd0:    axis_sel = axis_x;
      2'd1:    axis_sel = axis_y;
      default: axis_sel = axis_z;
    endcase
  end

  // shared multiplier operands
  logic signed [33:0] omc;
  logic signed [33:0] mul_a, mul_b;
  logic        [3:0]  op;
  assign omc = 34'(ONE_Q30) - cos_v;
  assign op  = cnt[3:0];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SUMSQ) begin
      mul_a = 34'(axis_sel);
      mul_b = 34'(axis_sel);
    end else begin
      case (op)
        4'd0:  begin mul_a = ux;     mul_b = ux;    end
        4'd1:  begin mul_a = ux;     mul_b = uy;    end
        4'd2:  begin mul_a = ux;     mul_b = uz;    end
        4'd3:  begin mul_a = uy;     mul_b = uy;    end
        4'd4:  begin mul_a = uy;     mul_b = uz;    end
        4'd5:  begin mul_a = uz;     mul_b = uz;    end
        4'd6:  begin mul_a = tmp[0]; mul_b = omc;   end
        4'd7:  begin mul_a = tmp[1]; mul_b = omc;   end
        4'd8:  begin mul_a = tmp[2]; mul_b = omc;   end
        4'd9:  begin mul_a = tmp[3]; mul_b = omc;   end
        4'd10: begin mul_a = tmp[4]; mul_b = omc;   end
        4'd11: begin mul_a = tmp[5]; mul_b = omc;   end
        4'd12: begin mul_a = uz;     mul_b = sin_v; end
        4'd13: begin mul_a = uy;     mul_b = sin_v; end
        4'd14: begin mul_a = ux;     mul_b = sin_v; end
        default: begin mul_a = '0;   mul_b = '0;    end
      endcase
    end
  end

  // rounded Q2.30 product and its destination
  logic signed [67:0] rnd_full;
  logic signed [33:0] rnd;
  logic        [3:0]  op_d;
  logic        [3:0]  wb_idx;
  assign rnd_full = (mul_p + 68'sh2000_0000) >>> 30;
  assign rnd      = rnd_full[33:0];
  assign op_d     = op - 4'd1;
  always_comb begin
    if (op_d < 4'd6)       wb_idx = op_d;
    else if (op_d < 4'd12) wb_idx = op_d - 4'd6;
    else                   wb_idx = op_d - 4'd6;
  end

  // sum of squares with the last product folded in
  logic [31:0] sum_new;
  assign sum_new = sum + mul_p[31:0];

  // square root step
  logic [60:0] sq_trial;
  logic        sq_take;
  logic [59:0] sq_res_next;
  assign sq_trial    = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take     = {1'b0, sq_n} >= sq_trial;
  assign sq_res_next = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  // divider step
  logic [32:0] rem_sh;
  logic        q_take;
  logic [59:0] quo_next;
  logic [59:0] q_cap;
  logic [15:0] mag;
  logic signed [33:0] u_new;
  assign rem_sh   = {rem, num[59]};
  assign q_take   = rem_sh >= {1'b0, r_val};
  assign quo_next = {quo[58:0], q_take};
  assign q_cap    = (quo_next > 60'h4000_0000) ? 60'h4000_0000 : quo_next;
  assign mag      = axis_sel[15] ? 16'(-axis_sel) : axis_sel;
  assign u_new    = axis_sel[15] ? -$signed({4'b0, q_cap[29:0]} | 34'(q_cap[30]) << 30)
                                 :  $signed({4'b0, q_cap[29:0]} | 34'(q_cap[30]) << 30);

  // cordic start angle and step
  logic signed [33:0] z_init;
  logic signed [33:0] z_start;
  logic               flip_start;
  logic        [4:0]  k;
  logic signed [33:0] atan_k;
  logic signed [33:0] cx_next, cy_next, cz_next;
  assign z_init = 34'($signed({rotation_angle, 16'b0}));
  always_comb begin
    if (z_init > 34'sh0_4000_0000) begin
      z_start    = z_init - 34'sh0_8000_0000;
      flip_start = 1'b1;
    end else if (z_init < -34'sh0_4000_0000) begin
      z_start    = z_init + 34'sh0_8000_0000;
      flip_start = 1'b1;
    end else begin
      z_start    = z_init;
      flip_start = 1'b0;
    end
  end
  assign k      = cnt[4:0];
  assign atan_k = $signed({2'b0, atan_turns(k)});
  always_comb begin
    if (cz >= 0) begin
      cx_next = cx - (cy >>> k);
      cy_next = cy + (cx >>> k);
      cz_next = cz - atan_k;
    end else begin
      cx_next = cx + (cy >>> k);
      cy_next = cy - (cx >>> k);
      cz_next = cz + atan_k;
    end
  end

  // matrix combine with clamp to [-1, 1]
  logic signed [35:0] m_raw [0:8];
  logic signed [31:0] m_sat [0:8];
  logic signed [35:0] c36;
  assign c36 = 36'(cos_v);
  always_comb begin
    m_raw[0] = c36 + 36'(tmp[0]);
    m_raw[1] = 36'(tmp[1]) - 36'(tmp[6]);
    m_raw[2] = 36'(tmp[2]) + 36'(tmp[7]);
    m_raw[3] = 36'(tmp[1]) + 36'(tmp[6]);
    m_raw[4] = c36 + 36'(tmp[3]);
    m_raw[5] = 36'(tmp[4]) - 36'(tmp[8]);
    m_raw[6] = 36'(tmp[2]) - 36'(tmp[7]);
    m_raw[7] = 36'(tmp[4]) + 36'(tmp[8]);
    m_raw[8] = c36 + 36'(tmp[5]);
    for (int i = 0; i < 9; i++) begin
      if (m_raw[i] > 36'(ONE_Q30))       m_sat[i] = ONE_Q30;
      else if (m_raw[i] < -36'(ONE_Q30)) m_sat[i] = -ONE_Q30;
      else                               m_sat[i] = m_raw[i][31:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (cfg_we && cfg_known) state_next = ST_SUMSQ;
      ST_SUMSQ:    if (cnt == 6'd3) state_next = (sum_new == '0) ? ST_IDLE : ST_SQRT;
      ST_SQRT:     if (cnt == 6'd29) state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      if (cnt == 6'd59) state_next = (ai == 2'd2) ? ST_CORDIC : ST_DIV_LOAD;
      ST_CORDIC:   if (cnt == 6'(CORDIC_STEPS - 1)) state_next = ST_COEF;
      ST_COEF:     if (cnt == 6'd15) state_next = ST_COMBINE;
      ST_COMBINE:  state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cnt            <= '0;
      ai             <= '0;
      axis_x         <= 16'sd0;
      axis_y         <= 16'sd0;
      axis_z         <= 16'sd1;
      rotation_angle <= '0;
      for (int i = 0; i < 9; i++) coef[i] <= (i % 4 == 0) ? ONE_Q30 : 32'sd0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else                     cnt <= cnt + 6'd1;
      case (state)
        ST_IDLE: begin
          ai <= '0;
          if (cfg_we) begin
            case (cfg_index)
              REG_AXIS_X: axis_x         <= cfg_data;
              REG_AXIS_Y: axis_y         <= cfg_data;
              REG_AXIS_Z: axis_z         <= cfg_data;
              REG_ANGLE:  rotation_angle <= cfg_data;
              default:    ;
            endcase
          end
        end
        ST_SUMSQ: begin
          if (cnt == 6'd3 && sum_new == '0) begin
            for (int i = 0; i < 9; i++) coef[i] <= (i % 4 == 0) ? ONE_Q30 : 32'sd0;
          end
        end
        ST_DIV: if (cnt == 6'd59) ai <= ai + 2'd1;
        ST_COMBINE: for (int i = 0; i < 9; i++) coef[i] <= m_sat[i];
        default: ;
      endcase
    end
  end

  // rebuild datapath registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      ST_IDLE: sum <= '0;
      ST_SUMSQ: begin
        if (cnt != 6'd0) sum <= sum_new;
        sq_n   <= {sum_new, 28'b0};
        sq_res <= '0;
        sq_bit <= 60'h1 << 58;
      end
      ST_SQRT: begin
        if (sq_take) sq_n <= sq_n - sq_trial[59:0];
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        r_val  <= sq_res_next[31:0];
      end
      ST_DIV_LOAD: begin
        num <= {mag, 44'b0} + 60'(r_val >> 1);
        rem <= '0;
        quo <= '0;
      end
      ST_DIV: begin
        rem <= q_take ? 32'(rem_sh - {1'b0, r_val}) : rem_sh[31:0];
        num <= num << 1;
        quo <= quo_next;
        if (cnt == 6'd59) begin
          case (ai)
            2'd0:    ux <= u_new;
            2'd1:    uy <= u_new;
            default: uz <= u_new;
          endcase
        end
        cx   <= CORDIC_GAIN;
        cy   <= '0;
        cz   <= z_start;
        flip <= flip_start;
      end
      ST_CORDIC: begin
        cx    <= cx_next;
        cy    <= cy_next;
        cz    <= cz_next;
        cos_v <= flip ? -cx_next : cx_next;
        sin_v <= flip ? -cy_next : cy_next;
      end
      ST_COEF: begin
        if (cnt != 6'd0) begin
          case (wb_idx)
            4'd0:    tmp[0] <= rnd;
            4'd1:    tmp[1] <= rnd;
            4'd2:    tmp[2] <= rnd;
            4'd3:    tmp[3] <= rnd;
            4'd4:    tmp[4] <= rnd;
            4'd5:    tmp[5] <= rnd;
            4'd6:    tmp[6] <= rnd;
            4'd7:    tmp[7] <= rnd;
            default: tmp[8] <= rnd;
          endcase
        end
      end
      default: ;
    endcase
  end

  // point pipeline: input, products, row sums, saturation
  logic               v1, v2, v3;
  logic signed [31:0] p1 [0:2];
  logic signed [63:0] prod [0:8];
  logic signed [35:0] row [0:2];
  logic signed [65:0] acc [0:2];
  logic signed [65:0] acc_sh [0:2];
  logic signed [31:0] sat_v [0:2];
  logic        [2:0]  sat_f;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(prod[r*3]) + 66'(prod[r*3+1]) + 66'(prod[r*3+2])
               + 66'sh2000_0000;
      acc_sh[r] = acc[r] >>> 30;
      if (row[r] > 36'sh0_7FFF_FFFF) begin
        sat_v[r] = 32'sh7FFF_FFFF;
        sat_f[r] = 1'b1;
      end else if (row[r] < -36'sh0_8000_0000) begin
        sat_v[r] = -32'sh8000_0000;
        sat_f[r] = 1'b1;
      end else begin
        sat_v[r] = row[r][31:0];
        sat_f[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
    p1[0] <= point.point_x;
    p1[1] <= point.point_y;
    p1[2] <= point.point_z;
    for (int i = 0; i < 9; i++) prod[i] <= coef[i] * p1[i % 3];
    for (int r = 0; r < 3; r++) row[r] <= acc_sh[r][35:0];
    result.rotated_x <= sat_v[0];
    result.rotated_y <= sat_v[1];
    result.rotated_z <= sat_v[2];
    result.saturated <= |sat_f;
  end

  // some output component sits at a rail
  logic clip_hit;
  assign clip_hit = (result.rotated_x == 32'sh7FFF_FFFF) ||
                    (result.rotated_x == -32'sh8000_0000) ||
                    (result.rotated_y == 32'sh7FFF_FFFF) ||
                    (result.rotated_y == -32'sh8000_0000) ||
                    (result.rotated_z == 32'sh7FFF_FFFF) ||
                    (result.rotated_z == -32'sh8000_0000);

  // checks
  `AAVR_ASSERT_NEXT(a_cfg_rebuild, cfg_we && cfg_known, busy, "write did not start rebuild")
  `AAVR_ASSERT_NOW(a_done_latency, done, $past(start && !busy, 4), "result without start beat")
  `AAVR_ASSERT_NOW(a_sat_extreme, done && result.saturated, clip_hit, "clip flag without clip")

endmodule

// ===== tb/sv/tb_axis_angle_vector_rotator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_axis_angle_vector_rotator
// Drives points and register writes into the rotator and checks every result
// beat against a bit-exact Rodrigues matrix predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb_axis_angle_vector_rotator
  import aavr_pkg::*;
();

  localparam int           ROT_STEPS   = 24;
  localparam int           DRAIN_IDLE  = 8;
  localparam logic [3:0]   REG_SPARE   = 4'd4;
  localparam logic [3:0]   REG_TOP     = 4'hF;
  localparam longint       Q30_ONE     = 64'sd1 << 30;
  localparam longint       Q30_HALF    = 64'sd1 << 29;
  localparam longint       GAIN_Q30    = 64'sh26DD3B6A;

  // arctangent of 2^-k, 2^-32 turn units
  localparam longint ATAN_TAB [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  typedef struct {
    bit          is_write;
    logic [3:0]  index;
    logic [15:0] data;
    point_t      pt;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  point_t      point = '0;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  stim_t   stim_q[$];
  result_t rotated_q[$];
  int      gap_left, burst_left, quiet;
  bit      all_sent;
  int      mismatches, beats_checked, writes_done;

  // predictor state
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [15:0]        angle_r;
  longint             coeff[9];

  always #4 clk = ~clk;

  axis_angle_vector_rotator #(.CORDIC_STEPS(ROT_STEPS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint mul_round(longint a, longint b);
    return (a * b + Q30_HALF) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint a, longint unsigned r);
    longint unsigned mag, q;
    mag = (a < 0) ? -a : a;
    q = ((mag << 44) + (r >> 1)) / r;
    if (q > Q30_ONE) q = Q30_ONE;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 9; i++) coeff[i] = (i % 4 == 0) ? Q30_ONE : 0;
  endtask

  // Rodrigues matrix from the current axis and angle
  task automatic rebuild_matrix();
    longint ax, ay, az, ux, uy, uz, z, x, y, dx, dy, c, s, omc, v;
    longint m[9];
    longint unsigned sumsq, r;
    bit flip;
    ax = ax_r; ay = ay_r; az = az_r;
    sumsq = ax * ax + ay * ay + az * az;
    if (sumsq == 0) begin
      load_identity();
      return;
    end
    r = int_sqrt(sumsq << 28);
    ux = unit_part(ax, r);
    uy = unit_part(ay, r);
    uz = unit_part(az, r);
    z = longint'($signed({angle_r, 16'h0000}));
    flip = 1'b0;
    if (z > Q30_ONE) begin
      z -= 64'sd1 << 31;
      flip = 1'b1;
    end else if (z < -Q30_ONE) begin
      z += 64'sd1 << 31;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i & 31];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i & 31];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = Q30_ONE - c;
    m[0] = c + mul_round(mul_round(ux, ux), omc);
    m[1] = mul_round(mul_round(ux, uy), omc) - mul_round(uz, s);
    m[2] = mul_round(mul_round(ux, uz), omc) + mul_round(uy, s);
    m[3] = mul_round(mul_round(uy, ux), omc) + mul_round(uz, s);
    m[4] = c + mul_round(mul_round(uy, uy), omc);
    m[5] = mul_round(mul_round(uy, uz), omc) - mul_round(ux, s);
    m[6] = mul_round(mul_round(uz, ux), omc) - mul_round(uy, s);
    m[7] = mul_round(mul_round(uz, uy), omc) + mul_round(ux, s);
    m[8] = c + mul_round(mul_round(uz, uz), omc);
    for (int i = 0; i < 9; i++) begin
      v = m[i];
      coeff[i] = (v > Q30_ONE) ? Q30_ONE : ((v < -Q30_ONE) ? -Q30_ONE : v);
    end
  endtask

  function automatic result_t rotate_point(point_t p);
    result_t res;
    longint  pv[3], acc, v;
    logic [31:0] comp[3];
    res.saturated = 1'b0;
    pv[0] = p.point_x; pv[1] = p.point_y; pv[2] = p.point_z;
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++) acc += coeff[row * 3 + col] * pv[col];
      v = (acc + Q30_HALF) >>> 30;
      if (v > 64'sh7FFFFFFF) begin
        v = 64'sh7FFFFFFF; res.saturated = 1'b1;
      end else if (v < -64'sh80000000) begin
        v = -64'sh80000000; res.saturated = 1'b1;
      end
      comp[row] = v[31:0];
    end
    res.rotated_x = comp[0];
    res.rotated_y = comp[1];
    res.rotated_z = comp[2];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_reg16();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    stim_t s;
    s.is_write = 1'b0; s.index = '0; s.data = '0;
    s.pt.point_x = x; s.pt.point_y = y; s.pt.point_z = z;
    stim_q = {stim_q, s};
  endtask

  task automatic add_write(logic [3:0] idx, logic [15:0] val);
    stim_t s;
    s.is_write = 1'b1; s.index = idx; s.data = val; s.pt = '0;
    stim_q = {stim_q, s};
  endtask

  // driver: bursts of beats with random gaps, writes only when drained
  always @(posedge clk) begin
    stim_t nxt;
    bit    pt_taken, wr_taken;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 4;
      quiet <= 0;
      all_sent <= 1'b0;
    end else begin
      pt_taken = start && !busy;
      wr_taken = cfg_valid && cfg_ready;
      quiet <= pt_taken ? 0 : ((quiet < 100) ? quiet + 1 : quiet);
      if ((start && !pt_taken) || (cfg_valid && !wr_taken)) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        all_sent <= 1'b1;
      end else begin
        nxt = stim_q[0];
        if (!nxt.is_write) begin
          cfg_valid <= 1'b0;
          start <= 1'b1;
          point <= nxt.pt;
          void'(stim_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
          // register writes wait until the datapath has drained
          if (!start && !busy && !wr_taken && quiet >= DRAIN_IDLE &&
              rotated_q.size() == 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= nxt.index;
            cfg_data <= nxt.data;
            void'(stim_q.pop_front());
          end else begin
            cfg_valid <= 1'b0;
          end
        end
      end
    end
  end

  // monitor: track writes and accepted points, check result beats
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ax_r = 16'sd0; ay_r = 16'sd0; az_r = 16'sd1; angle_r = 16'd0;
      load_identity();
    end else begin
      if (cfg_valid && cfg_ready) begin
        writes_done++;
        if (cfg_index <= REG_ANGLE) begin
          case (cfg_index)
            REG_AXIS_X: ax_r = cfg_data;
            REG_AXIS_Y: ay_r = cfg_data;
            REG_AXIS_Z: az_r = cfg_data;
            default:    angle_r = cfg_data;
          endcase
          rebuild_matrix();
        end
      end
      if (start && !busy) rotated_q = {rotated_q, rotate_point(point)};
      if (done) begin
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", result);
        end else begin
          want = rotated_q.pop_front();
          beats_checked++;
          if (result.rotated_x !== want.rotated_x || result.rotated_y !== want.rotated_y ||
              result.rotated_z !== want.rotated_z || result.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h %h %h sat %b, got %h %h %h sat %b",
                       want.rotated_x, want.rotated_y, want.rotated_z, want.saturated,
                       result.rotated_x, result.rotated_y, result.rotated_z,
                       result.saturated);
          end
        end
      end
    end
  end

  initial begin
    int n_phase;
    // identity after reset, coordinate extremes
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF);
    add_point(32'h00010000, 32'h00020000, 32'h00030000);
    // quarter turn about z, then an eighth turn that clips
    add_write(REG_ANGLE, 16'h4000);
    add_point(32'h00010000, 32'h00000000, 32'h00000000);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000);
    add_write(REG_ANGLE, 16'h2000);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000, 32'h12345678);
    // half turn and the top of the angle range
    add_write(REG_ANGLE, 16'h8000);
    add_point(32'h00010000, 32'hFFFF0000, 32'h00050000);
    add_write(REG_ANGLE, 16'hFFFF);
    add_point(32'h7FFFFFFF, 32'h00000000, 32'h80000000);
    // axis extremes
    add_write(REG_AXIS_X, 16'h7FFF);
    add_write(REG_AXIS_Y, 16'h8000);
    add_write(REG_AXIS_Z, 16'h8000);
    add_write(REG_ANGLE, 16'hC000);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    // zero axis falls back to identity
    add_write(REG_AXIS_X, 16'h0000);
    add_write(REG_AXIS_Y, 16'h0000);
    add_write(REG_AXIS_Z, 16'h0000);
    add_point(32'h13579BDF, 32'h80000000, 32'h7FFFFFFF);
    // write to an unused index keeps the matrix
    add_write(REG_SPARE, 16'h1234);
    add_write(REG_TOP, 16'hFFFF);
    add_point(32'h00010000, 32'h00020000, 32'h00030000);

    n_phase = 0;
    for (int i = 0; i < 1500; i++) begin
      if (i % 100 == 0) begin
        n_phase = $urandom_range(1, 4);
        for (int w = 0; w < n_phase; w++) begin
          if ($urandom_range(0, 9) == 0)
            add_write(4'($urandom_range(REG_SPARE, REG_TOP)), 16'($urandom));
          else
            add_write(4'($urandom_range(REG_AXIS_X, REG_ANGLE)), rand_reg16());
        end
      end
      add_point(rand_coord(), rand_coord(), rand_coord());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!(all_sent && rotated_q.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d rotated points across %0d register writes", beats_checked,
             writes_done);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, rotated_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/aavr_pkg.sv
hdl/axis_angle_vector_rotator.sv
tb/sv/tb_axis_angle_vector_rotator.sv
